// File: sv/u2u_pkg.sv
// Shared types, constants and the UTF-8 encoder for the transcoder.
`timescale 1ns / 1ps
package u2u_pkg;

	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [15:0] UnitCr = 16'h000d;
	localparam logic [15:0] UnitLf = 16'h000a;
	localparam logic [7:0] ByteQuote1 = 8'h91;
	localparam logic [7:0] ByteQuote2 = 8'h92;
	localparam logic [7:0] ByteDquote1 = 8'h93;
	localparam logic [7:0] ByteDquote2 = 8'h94;
	localparam logic [7:0] ByteApos = 8'h27;
	localparam logic [7:0] ByteDquote = 8'h22;
	localparam logic [7:0] ByteCr = 8'h0d;
	localparam logic [7:0] ByteLf = 8'h0a;
	localparam logic [5:0] HighSurrTag = 6'h36;
	localparam logic [20:0] SuppBase = 21'h010000;

	localparam logic MODE_ASCII = 1'b0;
	localparam logic MODE_UTF16 = 1'b1;

	// One queued item: up to four bytes and how many of them are used (1..4).
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic   full;
		logic   empty;
		entry_t head;
	} q_stat_t;

	function automatic entry_t utf8_encode(input logic [20:0] cp);
		entry_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.bytes[0] = cp[7:0];
			e.cnt = 3'd1;
		end else if (cp < 21'h800) begin
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
			e.cnt = 3'd2;
		end else if (cp < 21'h10000) begin
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
			e.cnt = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
			e.cnt = 3'd4;
		end
		return e;
	endfunction

endpackage

// File: sv/u2u_front.sv
// Front end: accepts input units, tracks surrogate and stop state, encodes to bytes.
`timescale 1ns / 1ps
module u2u_front
	import u2u_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_mode,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        block_start,
	input  q_stat_t     q_stat,
	output q_push_t     q_push
);

	logic [9:0] pending_high_q;
	logic       pending_valid_q;
	logic       stopped_q;

	logic       accept;
	logic [9:0] ph;
	logic       pv;
	logic       stp;
	logic [9:0] ph_nxt;
	logic       pv_nxt;
	logic       stp_nxt;
	logic [7:0] c;
	logic [20:0] cp;
	logic       emit;
	entry_t     enc;

	assign in_stall = q_stat.full;
	assign accept = in_valid && !q_stat.full;

	always_comb begin
		// A block start clears everything before this unit is looked at.
		ph = block_start ? 10'd0 : pending_high_q;
		pv = block_start ? 1'b0 : pending_valid_q;
		stp = block_start ? 1'b0 : stopped_q;
		ph_nxt = ph;
		pv_nxt = pv;
		stp_nxt = stp;
		emit = 1'b0;
		cp = '0;
		enc = '0;
		c = code_unit[7:0];
		if (!stp) begin
			if (text_mode == MODE_ASCII) begin
				if (c == 8'd0) begin
					stp_nxt = 1'b1;
				end else begin
					emit = 1'b1;
					priority if (c == ByteQuote1 || c == ByteQuote2) begin
						enc.bytes[0] = ByteApos;
					end else if (c == ByteDquote1 || c == ByteDquote2) begin
						enc.bytes[0] = ByteDquote;
					end else if (c == ByteCr) begin
						enc.bytes[0] = ByteLf;
					end else begin
						enc.bytes[0] = c;
					end
					enc.cnt = 3'd1;
				end
			end else begin
				priority if (pv) begin
					cp = SuppBase + {1'b0, ph, code_unit[9:0]};
					pv_nxt = 1'b0;
					ph_nxt = 10'd0;
					emit = 1'b1;
				end else if (code_unit[15:10] == HighSurrTag) begin
					ph_nxt = code_unit[9:0];
					pv_nxt = 1'b1;
				end else if (code_unit == 16'd0) begin
					stp_nxt = 1'b1;
				end else begin
					cp = {5'd0, (code_unit == UnitCr) ? UnitLf : code_unit};
					emit = 1'b1;
				end
				enc = utf8_encode(cp);
			end
		end
	end

	assign q_push.valid = accept && emit;
	assign q_push.entry = enc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_high_q <= '0;
			pending_valid_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			pending_high_q <= ph_nxt;
			pending_valid_q <= pv_nxt;
			stopped_q <= stp_nxt;
		end
	end

endmodule

// File: sv/u2u_queue.sv
// Short queue of encoded items between the front end and the byte serializer.
`timescale 1ns / 1ps
module u2u_queue
	import u2u_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t q_push,
	input  logic    pop,
	output q_stat_t q_stat
);

	entry_t             mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QCntW-1:0]   cnt_q;

	assign q_stat.full = (cnt_q == QCntW'(QDepth));
	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			mem_q[wr_ptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({q_push.valid, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/u2u_back.sv
// Back end: walks the queue head byte by byte into the output register.
`timescale 1ns / 1ps
module u2u_back
	import u2u_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  q_stat_t    q_stat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       adv;
	logic       load;
	logic       is_last;

	assign adv = !out_valid_q || !out_stall;
	assign load = adv && !q_stat.empty;
	assign is_last = ({1'b0, idx_q} + 3'd1) == q_stat.head.cnt;
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= !q_stat.empty;
			end
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= q_stat.head.bytes[idx_q];
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last_byte = last_q;

endmodule

// File: sv/utf16_or_ascii_to_utf8_core.sv
// Top level of the UTF-16 / Word-ASCII to UTF-8 transcoder.
//
// Input channel (in_valid/in_stall): one code_unit per transfer, with block_start
// marking the first unit of a new block. Output channel (out_valid/out_stall):
// one UTF-8 byte per transfer, last_byte set on the final byte of each encoded character.
// text_mode is written through text_mode_we/text_mode_wdata, by the user only
// while idle, which the block does not enforce (1 = UTF-16 LE units,
// 0 = Word-ASCII bytes); it resets to UTF-16. An item is written into the queue,
// then loaded into the output register, which presents its first byte.
// The output register emits one byte per cycle unless the receiver stalls;
// items have 1 to 4 bytes, three for most BMP units, and units that produce
// nothing are not queued. A four-entry queue between the front end and the
// serializer absorbs the difference between input units and output bytes.
// When the receiver stalls, the output byte holds and the queue fills; once it
// is full, in_stall rises. Reset empties the queue, drops any held high
// surrogate and clears the stopped condition left by a NUL.
`timescale 1ns / 1ps
module utf16_or_ascii_to_utf8_core
	import u2u_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_mode_we,
	input  logic        text_mode_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        block_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte
);

	logic    text_mode_q;
	q_push_t q_push;
	q_stat_t q_stat;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q <= MODE_UTF16;
		end else if (text_mode_we) begin
			text_mode_q <= text_mode_wdata;
		end
	end

	u2u_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_mode   (text_mode_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.block_start (block_start),
		.q_stat      (q_stat),
		.q_push      (q_push)
	);

	u2u_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (pop),
		.q_stat (q_stat)
	);

	u2u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

// File: sv/u2u_checker.sv
// Port-level checks of the transcoder output stream, bound to the top level.
`timescale 1ns / 1ps
module u2u_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       last_byte
);

	// A stalled byte stays as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
		else $error("output byte changed while stalled");

	// The bytes of one sequence leave without gaps when the receiver keeps up.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> out_valid)
		else $error("gap inside a UTF-8 sequence");

	// Every byte after a non-final byte is a continuation byte.
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> out_byte[7:6] == 2'b10)
		else $error("non-continuation byte inside a UTF-8 sequence");

	// A non-final byte is never plain ASCII.
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_byte |-> out_byte[7])
		else $error("ASCII byte not marked as last");

endmodule

bind utf16_or_ascii_to_utf8_core u2u_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.last_byte (last_byte)
);
